@@ rtl/deflate_fixed_huffman_encoder_macros.svh @@
// Assertion macros used by the encoder top level.
`ifndef DEFLATE_FIXED_HUFFMAN_ENCODER_MACROS_SVH
`define DEFLATE_FIXED_HUFFMAN_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define DFHE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("encoder property violated");
// Condition that must never be seen at a clock edge outside reset.
`define DFHE_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("encoder forbidden condition seen");
`else
`define DFHE_ASSERT(label, prop)
`define DFHE_NEVER(label, cond)
`endif
`endif

@@ rtl/dfhe_pkg.sv @@
// Types, constants and code tables of the fixed-Huffman token encoder.
package dfhe_pkg;

  // Token kinds as they arrive on the request channel.
  typedef enum logic [1:0] {
    REQ_HEADER  = 2'd0,
    REQ_LITERAL = 2'd1,
    REQ_MATCH   = 2'd2,
    REQ_END     = 2'd3
  } req_type_e;

  // Classified work handed from the front end to the back end.
  typedef enum logic [2:0] {
    JOB_HEADER,
    JOB_LITERAL,
    JOB_MATCH,
    JOB_END,
    JOB_ERROR
  } job_kind_e;

  // Position within the four words of a match.
  typedef enum logic [1:0] {
    STEP_LEN_CODE,
    STEP_LEN_EXTRA,
    STEP_DIST_CODE,
    STEP_DIST_EXTRA
  } match_step_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        bfinal;
    logic [7:0]  literal_value;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
    logic [4:0]  len_idx;
    logic [4:0]  dist_idx;
  } job_t;

  typedef struct packed {
    logic [12:0] code_bits;
    logic [3:0]  bit_count;
    logic        is_extra;
    logic        last_of_run;
    logic        range_error;
  } result_t;

  // Queue depth between front and back end.
  localparam int unsigned DFHE_FIFO_DEPTH = 2;

  // Literal code ranges.
  localparam logic [7:0]  LIT_SPLIT   = 8'd144;
  localparam logic [12:0] LIT_BASE_LO = 13'h030;
  localparam logic [12:0] LIT_BASE_HI = 13'h190;

  // Length symbols from 280 on use 8-bit codes starting at 0xC0.
  localparam logic [4:0]  LEN_IDX_LONG  = 5'd23;
  localparam logic [12:0] LEN_CODE_LONG = 13'h0C0;

  // Valid match ranges.
  localparam logic [8:0]  LEN_MIN  = 9'd3;
  localparam logic [8:0]  LEN_MAX  = 9'd258;
  localparam logic [15:0] DIST_MIN = 16'd1;
  localparam logic [15:0] DIST_MAX = 16'd32768;

  localparam int unsigned NUM_LEN  = 29;
  localparam int unsigned NUM_DIST = 30;

  // Code widths of the fixed-size items.
  localparam logic [3:0] HDR_BITS      = 4'd3;
  localparam logic [3:0] LIT_BITS_LO   = 4'd8;
  localparam logic [3:0] LIT_BITS_HI   = 4'd9;
  localparam logic [3:0] LEN_BITS_LO   = 4'd7;
  localparam logic [3:0] LEN_BITS_HI   = 4'd8;
  localparam logic [3:0] DIST_BITS     = 4'd5;
  localparam logic [3:0] EOB_BITS      = 4'd7;

  localparam logic [8:0] LEN_BASE [NUM_LEN] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15,
    9'd17, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67,
    9'd83, 9'd99, 9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };
  localparam logic [3:0] LEN_XBITS [NUM_LEN] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd0
  };
  localparam logic [15:0] DIST_BASE [NUM_DIST] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17,
    16'd25, 16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257,
    16'd385, 16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073,
    16'd4097, 16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
  };
  localparam logic [3:0] DIST_XBITS [NUM_DIST] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4,
    4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9,
    4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

endpackage

@@ rtl/dfhe_req_if.sv @@
// Request channel carrying one LZ77 token per word.
interface dfhe_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        bfinal;
  logic [7:0]  literal_value;
  logic [8:0]  match_length;
  logic [15:0] match_distance;

  modport source (
    output valid, req_type, bfinal, literal_value, match_length, match_distance,
    input  ready
  );
  modport sink (
    input  valid, req_type, bfinal, literal_value, match_length, match_distance,
    output ready
  );
endinterface

@@ rtl/dfhe_res_if.sv @@
// Result channel carrying one code word or extra-bit field per word.
interface dfhe_res_if;
  logic        valid;
  logic        ready;
  logic [12:0] code_bits;
  logic [3:0]  bit_count;
  logic        is_extra;
  logic        last_of_run;
  logic        range_error;

  modport source (
    output valid, code_bits, bit_count, is_extra, last_of_run, range_error,
    input  ready
  );
  modport sink (
    input  valid, code_bits, bit_count, is_extra, last_of_run, range_error,
    output ready
  );
endinterface

@@ rtl/dfhe_front.sv @@
// Front end: accepts tokens, checks match ranges and finds the code indexes.
module dfhe_front
  import dfhe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dfhe_req_if.sink   req_i,
  output logic       job_valid_o,
  input  logic       job_ready_i,
  output job_t       job_o
);

  logic  valid_q, valid_d;
  job_t  job_q, job_d;
  logic  in_fire;
  logic  range_bad;
  logic [4:0] len_idx;
  logic [4:0] dist_idx;

  assign req_i.ready = !valid_q || job_ready_i;
  assign in_fire     = req_i.valid && req_i.ready;

  // A match is rejected when either field leaves its legal range.
  assign range_bad = (req_i.match_length < LEN_MIN) || (req_i.match_length > LEN_MAX) ||
                     (req_i.match_distance < DIST_MIN) || (req_i.match_distance > DIST_MAX);

  // Base table search: the last entry not above the value wins.
  always_comb begin
    len_idx = '0;
    for (int i = 1; i < NUM_LEN; i++) begin
      if (req_i.match_length >= LEN_BASE[i]) begin
        len_idx = 5'(i);
      end
    end
  end

  always_comb begin
    dist_idx = '0;
    for (int i = 1; i < NUM_DIST; i++) begin
      if (req_i.match_distance >= DIST_BASE[i]) begin
        dist_idx = 5'(i);
      end
    end
  end

  // Classify the token into a job for the back end.
  always_comb begin
    job_d                = job_q;
    valid_d              = valid_q;
    if (job_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_fire) begin
      valid_d              = 1'b1;
      job_d.bfinal         = req_i.bfinal;
      job_d.literal_value  = req_i.literal_value;
      job_d.match_length   = req_i.match_length;
      job_d.match_distance = req_i.match_distance;
      job_d.len_idx        = len_idx;
      job_d.dist_idx       = dist_idx;
      case (req_type_e'(req_i.req_type))
        REQ_HEADER:  job_d.kind = JOB_HEADER;
        REQ_LITERAL: job_d.kind = JOB_LITERAL;
        REQ_MATCH:   job_d.kind = range_bad ? JOB_ERROR : JOB_MATCH;
        REQ_END:     job_d.kind = JOB_END;
        default:     job_d.kind = JOB_END;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

@@ rtl/dfhe_fifo.sv @@
// Short job queue between the front end and the back end.
module dfhe_fifo
  import dfhe_pkg::*;
#(
  parameter int unsigned Depth = DFHE_FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/dfhe_back.sv @@
// Back end: expands each job into its code words and drives the result register.
module dfhe_back
  import dfhe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_pop_o,
  input  job_t       job_i,
  dfhe_res_if.source res_o
);

  match_step_e step_q, step_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  result_t     word;
  logic        load;
  logic [12:0] len_extra;
  logic [12:0] dist_extra;

  // The result register takes a new word whenever it is empty or being drained.
  assign load = job_valid_i && (!out_valid_q || res_o.ready);

  assign len_extra  = 13'(job_i.match_length - LEN_BASE[job_i.len_idx]);
  assign dist_extra = 13'(job_i.match_distance - DIST_BASE[job_i.dist_idx]);

  // Next step: only a match walks through the four steps.
  always_comb begin
    step_d = step_q;
    if (load && (job_i.kind == JOB_MATCH)) begin
      if (step_q == STEP_DIST_EXTRA) begin
        step_d = STEP_LEN_CODE;
      end else begin
        step_d = match_step_e'(step_q + 2'd1);
      end
    end
  end

  // Word for the current job and step.
  always_comb begin
    word = '0;
    word.last_of_run = 1'b1;
    case (job_i.kind)
      JOB_HEADER: begin
        word.code_bits = {10'd0, job_i.bfinal, 2'b10};
        word.bit_count = HDR_BITS;
      end
      JOB_LITERAL: begin
        if (job_i.literal_value < LIT_SPLIT) begin
          word.code_bits = LIT_BASE_LO + 13'(job_i.literal_value);
          word.bit_count = LIT_BITS_LO;
        end else begin
          word.code_bits = LIT_BASE_HI + 13'(job_i.literal_value - LIT_SPLIT);
          word.bit_count = LIT_BITS_HI;
        end
      end
      JOB_END: begin
        word.bit_count = EOB_BITS;
      end
      JOB_ERROR: begin
        word.range_error = 1'b1;
      end
      JOB_MATCH: begin
        word.last_of_run = 1'b0;
        case (step_q)
          STEP_LEN_CODE: begin
            if (job_i.len_idx < LEN_IDX_LONG) begin
              word.code_bits = 13'(job_i.len_idx) + 13'd1;
              word.bit_count = LEN_BITS_LO;
            end else begin
              word.code_bits = LEN_CODE_LONG + 13'(job_i.len_idx - LEN_IDX_LONG);
              word.bit_count = LEN_BITS_HI;
            end
          end
          STEP_LEN_EXTRA: begin
            word.code_bits = len_extra;
            word.bit_count = LEN_XBITS[job_i.len_idx];
            word.is_extra  = 1'b1;
          end
          STEP_DIST_CODE: begin
            word.code_bits = 13'(job_i.dist_idx);
            word.bit_count = DIST_BITS;
          end
          STEP_DIST_EXTRA: begin
            word.code_bits   = dist_extra;
            word.bit_count   = DIST_XBITS[job_i.dist_idx];
            word.is_extra    = 1'b1;
            word.last_of_run = 1'b1;
          end
          default: begin
            word.bit_count = '0;
          end
        endcase
      end
      default: begin
        word.range_error = 1'b1;
      end
    endcase
  end

  // A job leaves the queue with its last word.
  assign job_pop_o = load && ((job_i.kind != JOB_MATCH) || (step_q == STEP_DIST_EXTRA));

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (!out_valid_q || res_o.ready) begin
      out_valid_d = job_valid_i;
      out_d       = word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_LEN_CODE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.code_bits   = out_q.code_bits;
  assign res_o.bit_count   = out_q.bit_count;
  assign res_o.is_extra    = out_q.is_extra;
  assign res_o.last_of_run = out_q.last_of_run;
  assign res_o.range_error = out_q.range_error;

endmodule

@@ rtl/deflate_fixed_huffman_encoder.sv @@
// DEFLATE fixed-Huffman token encoder (block type 01). Each word on req_i is one
// LZ77 token: a block header, a literal, a length/distance match or an end of
// block. Each token gives value/bit-count words on res_o, the last one marked by
// last_of_run; packing into bytes is done downstream. Headers, literals, end of
// block and out-of-range matches give one word; a valid match gives four (length
// code, length extras, distance code, distance extras), and extras words may
// carry zero bits. The result port moves one word per cycle while res_o.ready
// holds. A token passes through the front-stage register and a queue entry before
// its first word is loaded into the result register. The front stage accepts a
// new token every cycle as long as the job queue has room.
`include "deflate_fixed_huffman_encoder_macros.svh"
module deflate_fixed_huffman_encoder
  import dfhe_pkg::*;
#(
  parameter int unsigned FifoDepth = DFHE_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfhe_req_if.sink   req_i,
  dfhe_res_if.source res_o
);

  logic job_push;
  logic job_push_ready;
  job_t job_in;
  logic job_valid;
  logic job_pop;
  job_t job_head;

  dfhe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_valid_o (job_push),
    .job_ready_i (job_push_ready),
    .job_o       (job_in)
  );

  dfhe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_push),
    .push_ready_o (job_push_ready),
    .push_data_i  (job_in),
    .pop_valid_o  (job_valid),
    .pop_i        (job_pop),
    .pop_data_o   (job_head)
  );

  dfhe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job_head),
    .res_o       (res_o)
  );

  // An error word is alone in its run and carries no bits.
  `DFHE_ASSERT(a_error_word_shape, res_o.valid && res_o.range_error |-> res_o.last_of_run && (res_o.bit_count == 4'd0) && !res_o.is_extra)
  // Extras never exceed thirteen bits and never come with an error.
  `DFHE_ASSERT(a_extra_word_shape, res_o.valid && res_o.is_extra |-> (res_o.bit_count <= 4'd13) && !res_o.range_error)
  // A queue pop only happens while a job is present.
  `DFHE_NEVER(a_pop_empty, job_pop && !job_valid)

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the DEFLATE fixed-Huffman token encoder.
`timescale 1ns / 1ps

module tb
  import dfhe_pkg::*;
();

  localparam int unsigned LONG_STALL_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT       = 200000;
  localparam int unsigned DRAIN_CYCLES      = 16;

  // One LZ77 token as offered on the request channel.
  typedef struct packed {
    req_type_e   kind;
    logic        last;
    logic [7:0]  lit;
    logic [8:0]  len;
    logic [15:0] distance;
  } token_t;

  // One expected word on the result channel.
  typedef struct packed {
    logic [12:0] bits;
    logic [3:0]  cnt;
    logic        extra;
    logic        last;
    logic        err;
  } code_word_t;

  logic clk;
  logic rst_n;

  dfhe_req_if req_if ();
  dfhe_res_if res_if ();

  deflate_fixed_huffman_encoder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  token_t      token_q[$];
  code_word_t  code_q[$];

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_words;
  int unsigned n_errors;
  int unsigned n_headers;
  int unsigned n_literals;
  int unsigned n_matches;
  int unsigned n_bad_matches;
  int unsigned n_ends;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt;
  int unsigned long_stall_left;
  logic        long_stall_req;
  logic        long_stall_done;

  // Length buckets: eight single values, then groups of four per extra-bit width, then 258.
  function automatic int unsigned len_bucket_bits(int unsigned idx);
    if (idx < 8 || idx == 28) return 0;
    return (idx - 4) / 4;
  endfunction

  function automatic int unsigned len_bucket_base(int unsigned idx);
    if (idx == 28) return 258;
    if (idx < 8) return idx + 3;
    return ((4 + idx % 4) << len_bucket_bits(idx)) + 3;
  endfunction

  // Distance buckets: four single values, then pairs per extra-bit width.
  function automatic int unsigned dist_bucket_bits(int unsigned idx);
    if (idx < 4) return 0;
    return idx / 2 - 1;
  endfunction

  function automatic int unsigned dist_bucket_base(int unsigned idx);
    if (idx < 4) return idx + 1;
    return ((2 + idx % 2) << dist_bucket_bits(idx)) + 1;
  endfunction

  function automatic void push_word(int unsigned bits, int unsigned cnt, logic extra,
                                    logic last, logic err);
    code_word_t w;
    w.bits  = 13'(bits);
    w.cnt   = 4'(cnt);
    w.extra = extra;
    w.last  = last;
    w.err   = err;
    code_q.push_back(w);
  endfunction

  // Works out the code words that one accepted token must produce.
  function automatic void encode_token(token_t t);
    int unsigned li;
    int unsigned di;
    li = 0;
    di = 0;
    case (t.kind)
      REQ_HEADER: begin
        n_headers++;
        push_word({t.last, 2'b10}, 3, 1'b0, 1'b1, 1'b0);
      end
      REQ_LITERAL: begin
        n_literals++;
        if (t.lit < 144) push_word(32'h30 + t.lit, 8, 1'b0, 1'b1, 1'b0);
        else push_word(32'h190 + t.lit - 144, 9, 1'b0, 1'b1, 1'b0);
      end
      REQ_END: begin
        n_ends++;
        push_word(0, 7, 1'b0, 1'b1, 1'b0);
      end
      default: begin
        n_matches++;
        if (t.len < 3 || t.len > 258 || t.distance < 1 || t.distance > 32768) begin
          n_bad_matches++;
          push_word(0, 0, 1'b0, 1'b1, 1'b1);
        end else begin
          for (int unsigned i = 1; i < 29; i++) if (t.len >= len_bucket_base(i)) li = i;
          for (int unsigned i = 1; i < 30; i++) if (t.distance >= dist_bucket_base(i)) di = i;
          // Symbols 257 to 279 take 7 bits, 280 to 285 take 8 bits.
          if (li < 23) push_word(li + 1, 7, 1'b0, 1'b0, 1'b0);
          else push_word(32'hC0 + li - 23, 8, 1'b0, 1'b0, 1'b0);
          push_word(t.len - len_bucket_base(li), len_bucket_bits(li), 1'b1, 1'b0, 1'b0);
          push_word(di, 5, 1'b0, 1'b0, 1'b0);
          push_word(t.distance - dist_bucket_base(di), dist_bucket_bits(di), 1'b1, 1'b1,
                    1'b0);
        end
      end
    endcase
  endfunction

  function automatic void queue_token(req_type_e kind, logic last, int unsigned lit,
                                      int unsigned len, int unsigned distance);
    token_t t;
    t.kind     = kind;
    t.last     = last;
    t.lit      = 8'(lit);
    t.len      = 9'(len);
    t.distance = 16'(distance);
    token_q.push_back(t);
    n_queued++;
  endfunction

  // Picks a value inside the given bucket, often at one of its ends.
  function automatic int unsigned pick_in_bucket(int unsigned base, int unsigned xbits);
    int unsigned span;
    span = (1 << xbits) - 1;
    case ($urandom_range(3))
      0: return base;
      1: return base + span;
      default: return base + $urandom_range(span);
    endcase
  endfunction

  // Random token of the given kind; the fields that kind ignores stay random.
  function automatic void queue_random(req_type_e kind);
    int unsigned idx;
    int unsigned len;
    int unsigned dist_val;
    len      = $urandom_range(511);
    dist_val = $urandom_range(65535);
    if (kind == REQ_MATCH) begin
      if ($urandom_range(99) < 88) begin
        idx      = $urandom_range(28);
        len      = pick_in_bucket(len_bucket_base(idx), len_bucket_bits(idx));
        idx      = $urandom_range(29);
        dist_val = pick_in_bucket(dist_bucket_base(idx), dist_bucket_bits(idx));
      end else begin
        case ($urandom_range(3))
          0: len = $urandom_range(2);
          1: len = $urandom_range(511, 259);
          2: dist_val = 0;
          default: dist_val = $urandom_range(65535, 32769);
        endcase
      end
    end
    queue_token(kind, 1'($urandom_range(1)), $urandom_range(255), len, dist_val);
  endfunction

  // Queues whole blocks (header, literals and matches, end) with some stray tokens.
  function automatic void queue_blocks(int unsigned n_items);
    int unsigned target;
    int unsigned body;
    target = n_queued + n_items;
    while (n_queued < target) begin
      if ($urandom_range(9) == 0) queue_random(req_type_e'($urandom_range(3)));
      queue_random(REQ_HEADER);
      body = $urandom_range(10, 2);
      repeat (body) queue_random($urandom_range(99) < 45 ? REQ_LITERAL : REQ_MATCH);
      queue_random(REQ_END);
    end
  endfunction

  task automatic wait_idle();
    while (n_accepted != n_queued || code_q.size() != 0) @(posedge clk);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: offers the next pending token when the channel is free, idling at random per send_idle_pct.
  always @(posedge clk or negedge rst_n) begin : req_driver
    token_t nxt;
    token_t got;
    if (!rst_n) begin
      req_if.valid          <= 1'b0;
      req_if.req_type       <= REQ_HEADER;
      req_if.bfinal         <= 1'b0;
      req_if.literal_value  <= '0;
      req_if.match_length   <= '0;
      req_if.match_distance <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        got.kind     = req_type_e'(req_if.req_type);
        got.last     = req_if.bfinal;
        got.lit      = req_if.literal_value;
        got.len      = req_if.match_length;
        got.distance = req_if.match_distance;
        encode_token(got);
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (token_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = token_q.pop_front();
          req_if.valid          <= 1'b1;
          req_if.req_type       <= nxt.kind;
          req_if.bfinal         <= nxt.last;
          req_if.literal_value  <= nxt.lit;
          req_if.match_length   <= nxt.len;
          req_if.match_distance <= nxt.distance;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long output stall, started once on request.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      long_stall_left <= 0;
      long_stall_done <= 1'b0;
    end else if (long_stall_req && !long_stall_done) begin
      long_stall_left <= LONG_STALL_CYCLES;
      long_stall_done <= 1'b1;
    end else if (long_stall_left != 0) begin
      long_stall_left <= long_stall_left - 1;
    end
  end

  // Result monitor: compares each accepted word with the oldest expectation.
  always @(posedge clk or negedge rst_n) begin : res_monitor
    code_word_t want;
    code_word_t seen;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen.bits  = res_if.code_bits;
        seen.cnt   = res_if.bit_count;
        seen.extra = res_if.is_extra;
        seen.last  = res_if.last_of_run;
        seen.err   = res_if.range_error;
        n_words++;
        if (code_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected word bits=%h cnt=%0d extra=%b last=%b err=%b",
                   $time, seen.bits, seen.cnt, seen.extra, seen.last, seen.err);
        end else begin
          want = code_q.pop_front();
          if (seen !== want) begin
            n_errors++;
            $display("%0t: mismatch expected bits=%h cnt=%0d extra=%b last=%b err=%b, %s",
                     $time, want.bits, want.cnt, want.extra, want.last, want.err,
                     $sformatf("got bits=%h cnt=%0d extra=%b last=%b err=%b",
                               seen.bits, seen.cnt, seen.extra, seen.last, seen.err));
          end
        end
      end
      res_if.ready <= (long_stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_cnt,
               code_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    long_stall_req  = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    n_queued        = 0;
    rst_n           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed tokens: field extremes, code-width boundaries and range errors.
    queue_token(REQ_HEADER, 1'b0, 8'hFF, 9'h1FF, 16'hFFFF);
    queue_token(REQ_HEADER, 1'b1, 0, 0, 0);
    queue_token(REQ_LITERAL, 1'b1, 0, 511, 65535);
    queue_token(REQ_LITERAL, 1'b0, 143, 0, 0);
    queue_token(REQ_LITERAL, 1'b1, 144, 0, 0);
    queue_token(REQ_LITERAL, 1'b0, 255, 0, 0);
    queue_token(REQ_MATCH, 1'b0, 0, 3, 1);
    queue_token(REQ_MATCH, 1'b1, 255, 258, 32768);
    queue_token(REQ_MATCH, 1'b0, 0, 257, 24577);
    queue_token(REQ_MATCH, 1'b0, 0, 10, 4);
    queue_token(REQ_MATCH, 1'b0, 0, 11, 5);
    queue_token(REQ_MATCH, 1'b0, 0, 114, 24576);
    queue_token(REQ_MATCH, 1'b0, 0, 115, 16385);
    queue_token(REQ_MATCH, 1'b0, 0, 2, 1);
    queue_token(REQ_MATCH, 1'b0, 0, 259, 1);
    queue_token(REQ_MATCH, 1'b0, 0, 3, 0);
    queue_token(REQ_MATCH, 1'b0, 0, 258, 32769);
    queue_token(REQ_MATCH, 1'b1, 8'hFF, 511, 65535);
    queue_token(REQ_MATCH, 1'b0, 0, 0, 0);
    queue_token(REQ_END, 1'b1, 8'hFF, 511, 65535);
    wait_idle();

    // Back-to-back blocks while the output holds off for a long stretch.
    long_stall_req = 1'b1;
    queue_blocks(90);
    wait_idle();

    // Mostly idle sender.
    send_idle_pct = 85;
    queue_blocks(90);
    wait_idle();

    // Mostly stalled receiver.
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    queue_blocks(90);
    wait_idle();

    // Light idling on both sides.
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    queue_blocks(90);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d tokens: %0d headers, %0d literals, %0d matches (%0d out of range), %0d ends.",
             n_accepted, n_headers, n_literals, n_matches, n_bad_matches, n_ends);
    $display("Checked %0d words under five idle settings, including a %0d-cycle output stall.",
             n_words, LONG_STALL_CYCLES);
    if (n_errors == 0 && code_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
